// ===== rtl/core/fcs_pkg.sv =====
// fcs_pkg: types, geometry constants and codes shared by the command splitter
// used by fcs_front, fcs_queue, fcs_back and flash_command_splitter_unit
package fcs_pkg;

   localparam int unsigned SUBSECTOR_BYTES = 4096;
   localparam int unsigned BLOCK_BYTES     = 65536;
   localparam int unsigned PAGE_BYTES      = 256;
   localparam int unsigned MAX_COMMANDS    = 64;

   localparam int unsigned ADDR_W   = 32;
   localparam int unsigned LEN_W    = 19;
   localparam int unsigned CHUNK_W  = 17;
   localparam int unsigned CMD_W    = 2;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned CSR_IDX_W = 2;

   localparam int unsigned SUB_BITS   = $clog2(SUBSECTOR_BYTES);
   localparam int unsigned BLOCK_BITS = $clog2(BLOCK_BYTES);
   localparam int unsigned PAGE_BITS  = $clog2(PAGE_BYTES);

   localparam longint unsigned MAX_ERASE_LEN = longint'(MAX_COMMANDS) * SUBSECTOR_BYTES;
   localparam longint unsigned MAX_WRITE_LEN = longint'(MAX_COMMANDS - 1) * PAGE_BYTES;

   localparam logic MODE_ERASE = 1'b0;
   localparam logic MODE_WRITE = 1'b1;

   localparam logic [CMD_W-1:0] CMD_NONE   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_BLOCK  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SECTOR = 2'd2;
   localparam logic [CMD_W-1:0] CMD_PAGE   = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OUTSIDE    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_MISALIGNED = 2'd2;
   localparam logic [STATUS_W-1:0] ST_TOO_LONG   = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_BASE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SIZE = 2'd1;

   localparam logic [ADDR_W-1:0] WINDOW_BASE_RESET = 32'd0;
   localparam logic [ADDR_W-1:0] WINDOW_SIZE_RESET = 32'd16777216;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

   // classified request handed from front to back
   typedef struct packed {
      logic                single;
      logic [STATUS_W-1:0] status;
      logic                mode;
      logic [ADDR_W-1:0]   offset;
      logic [ADDR_W-1:0]   source;
      logic [LEN_W-1:0]    length;
   } job_type;

endpackage

// ===== rtl/core/fcs_front.sv =====
// fcs_front: window registers and request classification
// depends on fcs_pkg; feeds fcs_queue
module fcs_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [fcs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [fcs_pkg::ADDR_W-1:0] csr_data,
   input  logic                       req_mode,
   input  logic [fcs_pkg::ADDR_W-1:0] req_address,
   input  logic [fcs_pkg::LEN_W-1:0]  req_byte_length,
   input  logic [fcs_pkg::ADDR_W-1:0] req_source_address,
   output fcs_pkg::job_type           job
);
   import fcs_pkg::*;

   logic [ADDR_W-1:0] window_base_ff, window_base_in;
   logic [ADDR_W-1:0] window_size_ff, window_size_in;
   logic [ADDR_W:0]   win_end;
   logic [ADDR_W-1:0] taddr;
   logic              outside, misaligned, too_long;

   assign csr_ready = 1'b1;

   always_comb begin
      window_base_in = window_base_ff;
      window_size_in = window_size_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_WINDOW_BASE: window_base_in = csr_data;
            CSR_WINDOW_SIZE: window_size_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_base_ff <= WINDOW_BASE_RESET;
         window_size_ff <= WINDOW_SIZE_RESET;
      end else begin
         window_base_ff <= window_base_in;
         window_size_ff <= window_size_in;
      end
   end

   always_comb begin
      win_end    = {1'b0, window_base_ff} + {1'b0, window_size_ff};
      outside    = (req_address < window_base_ff) || ({1'b0, req_address} > win_end);
      taddr      = req_address - window_base_ff;
      misaligned = (taddr[SUB_BITS-1:0] != '0) || (req_byte_length[SUB_BITS-1:0] != '0);
      if (req_mode == MODE_ERASE) begin
         too_long = {1'b0, req_byte_length} > (LEN_W+1)'(MAX_ERASE_LEN);
      end else begin
         too_long = {1'b0, req_byte_length} > (LEN_W+1)'(MAX_WRITE_LEN);
      end

      job.mode   = req_mode;
      job.offset = taddr;
      job.source = (req_mode == MODE_WRITE) ? req_source_address : '0;
      job.length = req_byte_length;
      job.single = 1'b1;
      if (outside) begin
         job.status = ST_OUTSIDE;
      end else if (req_mode == MODE_ERASE && misaligned) begin
         job.status = ST_MISALIGNED;
      end else if (too_long) begin
         job.status = ST_TOO_LONG;
      end else begin
         job.status = ST_OK;
         job.single = (req_byte_length == '0);
      end
   end

endmodule

// ===== rtl/core/fcs_queue.sv =====
// fcs_queue: short queue of classified requests between front and back
// depends on fcs_pkg
module fcs_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  fcs_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output fcs_pkg::job_type head_job
);
   import fcs_pkg::*;

   job_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_job = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== rtl/core/fcs_back.sv =====
// fcs_back: splits a queued request, one command per unstalled cycle
// depends on fcs_pkg; drains fcs_queue into the result register
module fcs_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_empty,
   input  fcs_pkg::job_type             q_job,
   output logic                         q_pop,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic [fcs_pkg::CMD_W-1:0]    rsp_command,
   output logic [fcs_pkg::ADDR_W-1:0]   rsp_flash_offset,
   output logic [fcs_pkg::ADDR_W-1:0]   rsp_data_address,
   output logic [fcs_pkg::CHUNK_W-1:0]  rsp_chunk_bytes,
   output logic [fcs_pkg::STATUS_W-1:0] rsp_status,
   output logic                         rsp_last
);
   import fcs_pkg::*;

   logic                busy_ff, busy_in;
   logic                mode_ff, mode_in;
   logic                first_ff, first_in;
   logic [LEN_W-1:0]    left_ff, left_in;
   logic [ADDR_W-1:0]   offset_ff, offset_in;
   logic [ADDR_W-1:0]   source_ff, source_in;

   logic                out_valid_ff, out_valid_in;
   logic [CMD_W-1:0]    cmd_ff, cmd_in;
   logic [ADDR_W-1:0]   off_out_ff, off_out_in;
   logic [ADDR_W-1:0]   data_out_ff, data_out_in;
   logic [CHUNK_W-1:0]  chunk_ff, chunk_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                last_ff, last_in;

   logic                out_free, emit;
   logic [LEN_W-1:0]    span, fill;
   logic [PAGE_BITS-1:0] start;
   logic [CMD_W-1:0]    step_cmd;

   assign out_free = !out_valid_ff || rsp_pop;

   // size of the next command
   always_comb begin
      start = first_ff ? offset_ff[PAGE_BITS-1:0] : '0;
      if (mode_ff == MODE_ERASE) begin
         if (offset_ff[BLOCK_BITS-1:0] == '0 && left_ff >= LEN_W'(BLOCK_BYTES)) begin
            step_cmd = CMD_BLOCK;
            span     = LEN_W'(BLOCK_BYTES);
         end else begin
            step_cmd = CMD_SECTOR;
            span     = LEN_W'(SUBSECTOR_BYTES);
         end
      end else begin
         step_cmd = CMD_PAGE;
         span     = LEN_W'(PAGE_BYTES) - LEN_W'(start);
      end
      fill = (span > left_ff) ? left_ff : span;
   end

   always_comb begin
      busy_in      = busy_ff;
      mode_in      = mode_ff;
      first_in     = first_ff;
      left_in      = left_ff;
      offset_in    = offset_ff;
      source_in    = source_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      cmd_in       = cmd_ff;
      off_out_in   = off_out_ff;
      data_out_in  = data_out_ff;
      chunk_in     = chunk_ff;
      status_in    = status_ff;
      last_in      = last_ff;
      q_pop        = 1'b0;
      emit         = 1'b0;
      if (busy_ff) begin
         if (out_free) begin
            emit         = 1'b1;
            out_valid_in = 1'b1;
            cmd_in       = step_cmd;
            off_out_in   = offset_ff;
            data_out_in  = source_ff;
            chunk_in     = fill[CHUNK_W-1:0];
            status_in    = ST_OK;
            last_in      = (left_ff == fill);
            offset_in    = offset_ff + ADDR_W'(fill);
            source_in    = (mode_ff == MODE_WRITE) ? source_ff + ADDR_W'(fill) : '0;
            left_in      = left_ff - fill;
            first_in     = 1'b0;
            busy_in      = (left_ff != fill);
         end
      end else if (!q_empty && out_free) begin
         q_pop = 1'b1;
         if (q_job.single) begin
            emit         = 1'b1;
            out_valid_in = 1'b1;
            cmd_in       = CMD_NONE;
            off_out_in   = '0;
            data_out_in  = '0;
            chunk_in     = '0;
            status_in    = q_job.status;
            last_in      = 1'b1;
         end else begin
            busy_in   = 1'b1;
            mode_in   = q_job.mode;
            first_in  = 1'b1;
            left_in   = q_job.length;
            offset_in = q_job.offset;
            source_in = q_job.source;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         mode_ff      <= MODE_ERASE;
         first_ff     <= 1'b0;
         left_ff      <= '0;
         offset_ff    <= '0;
         source_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         mode_ff      <= mode_in;
         first_ff     <= first_in;
         left_ff      <= left_in;
         offset_ff    <= offset_in;
         source_ff    <= source_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      off_out_ff  <= off_out_in;
      data_out_ff <= data_out_in;
      chunk_ff    <= chunk_in;
      status_ff   <= status_in;
      last_ff     <= last_in;
   end

   assign rsp_empty        = !out_valid_ff;
   assign rsp_command      = cmd_ff;
   assign rsp_flash_offset = off_out_ff;
   assign rsp_data_address = data_out_ff;
   assign rsp_chunk_bytes  = chunk_ff;
   assign rsp_status       = status_ff;
   assign rsp_last         = last_ff;

   a_last_ends_split: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && emit && last_in) |=> !busy_ff)
      else $error("split still busy after its final command");

   a_error_is_single: assert property (@(posedge clock) disable iff (reset)
      (emit && status_in != ST_OK) |-> (cmd_in == CMD_NONE && last_in))
      else $error("error result carries a command or is not final");

   a_command_has_bytes: assert property (@(posedge clock) disable iff (reset)
      (emit && cmd_in != CMD_NONE) |-> (chunk_in != '0))
      else $error("command with zero bytes");

   a_no_pop_while_busy: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (!busy_ff && !q_empty))
      else $error("queue popped while a split is running");

endmodule

// ===== rtl/core/flash_command_splitter_unit.sv =====
// flash_command_splitter_unit: top level of the flash erase/program command splitter
// depends on fcs_pkg, fcs_front, fcs_queue and fcs_back
//
//   channel   ports                                   direction
//   req       req_push/req_full + request fields      in
//   rsp       rsp_empty/rsp_pop + command fields      out
//   csr       csr_valid/csr_ready, csr_index/data     in
//
// a request is classified combinationally and registered into the queue; the back
// end then loads a split and emits its commands in turn, or emits a single
// result for an error or zero-length request
// the back end's one command per cycle, unless stalled, sets the sustained rate
// reset clears the queue, the splitter and the result register; window
// registers return to base 0, size 16 MiB
// a held result stalls the back end, and a full queue raises req_full
module flash_command_splitter_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [fcs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [fcs_pkg::ADDR_W-1:0]   csr_data,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic                         req_mode,
   input  logic [fcs_pkg::ADDR_W-1:0]   req_address,
   input  logic [fcs_pkg::LEN_W-1:0]    req_byte_length,
   input  logic [fcs_pkg::ADDR_W-1:0]   req_source_address,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic [fcs_pkg::CMD_W-1:0]    rsp_command,
   output logic [fcs_pkg::ADDR_W-1:0]   rsp_flash_offset,
   output logic [fcs_pkg::ADDR_W-1:0]   rsp_data_address,
   output logic [fcs_pkg::CHUNK_W-1:0]  rsp_chunk_bytes,
   output logic [fcs_pkg::STATUS_W-1:0] rsp_status,
   output logic                         rsp_last
);
   import fcs_pkg::*;

   job_type front_job, head_job;
   logic    q_empty, q_pop;

   fcs_front u_front (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_mode           (req_mode),
      .req_address        (req_address),
      .req_byte_length    (req_byte_length),
      .req_source_address (req_source_address),
      .job                (front_job)
   );

   fcs_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_push),
      .push_job (front_job),
      .full     (req_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head_job (head_job)
   );

   fcs_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_job            (head_job),
      .q_pop            (q_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_command      (rsp_command),
      .rsp_flash_offset (rsp_flash_offset),
      .rsp_data_address (rsp_data_address),
      .rsp_chunk_bytes  (rsp_chunk_bytes),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last)
   );

endmodule
